// File: sv/dqe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
package dqe_pkg;

	localparam int WORD_W      = 32;
	localparam int KIND_W      = 3;
	localparam int COUNT_OUT_W = 7;

	// Number of cell taps folded together in the first stage of the right-end tree.
	localparam int TAP_GROUP = 64;

	localparam logic [WORD_W-1:0] EMPTY_WORD = 32'h7FFF_FFFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_QUERY      = 3'd0,
		KIND_PUSH_RIGHT = 3'd1,
		KIND_PUSH_LEFT  = 3'd2,
		KIND_POP_LEFT   = 3'd3,
		KIND_POP_RIGHT  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GATHER,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic push_left;
		logic push_right;
		logic pop_left;
		logic pop_right;
	} cell_ctrl_t;

endpackage

// File: sv/dqe_cell.sv
`timescale 1ns / 1ps
// One storage cell of the deque chain: a word, its valid bit and the right-end tap.
module dqe_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dqe_pkg::cell_ctrl_t           ctrl,
	input  logic [dqe_pkg::WORD_W-1:0]    push_word,
	input  logic [dqe_pkg::WORD_W-1:0]    left_word,
	input  logic                          left_valid,
	input  logic [dqe_pkg::WORD_W-1:0]    right_word,
	input  logic                          right_valid,
	output logic [dqe_pkg::WORD_W-1:0]    word,
	output logic                          valid,
	output logic [dqe_pkg::WORD_W-1:0]    tap
);

	logic [dqe_pkg::WORD_W-1:0] word_q;
	logic                       valid_q;
	logic                       take_push;
	logic                       take_pop;

	// Entries are packed from the left, so the first empty cell takes a right push
	// and the last full cell gives up its word on a right pop.
	assign take_push = ctrl.push_right && !valid_q && left_valid;
	assign take_pop  = ctrl.pop_right && valid_q && !right_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push_left) begin
			valid_q <= left_valid;
		end else if (ctrl.pop_left) begin
			valid_q <= right_valid;
		end else if (take_push) begin
			valid_q <= 1'b1;
		end else if (take_pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_left) begin
			word_q <= left_word;
		end else if (ctrl.pop_left) begin
			word_q <= right_word;
		end else if (take_push) begin
			word_q <= push_word;
		end
	end

	assign word  = word_q;
	assign valid = valid_q;
	assign tap   = (valid_q && !right_valid) ? word_q : '0;

endmodule

// File: sv/dqe_right_tap.sv
`timescale 1ns / 1ps
// Registered OR tree that gathers the rightmost word from the one-hot cell taps.
module dqe_right_tap #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic [dqe_pkg::WORD_W-1:0]    tap [CAPACITY],
	output logic [dqe_pkg::WORD_W-1:0]    right_word
);

	localparam int GROUPS = (CAPACITY + dqe_pkg::TAP_GROUP - 1) / dqe_pkg::TAP_GROUP;

	logic [dqe_pkg::WORD_W-1:0] group_d [GROUPS];
	logic [dqe_pkg::WORD_W-1:0] group_q [GROUPS];

	// At most one tap is non-zero, so an OR picks it out.
	always_comb begin
		int idx;
		for (int g = 0; g < GROUPS; g++) begin
			group_d[g] = '0;
			for (int j = 0; j < dqe_pkg::TAP_GROUP; j++) begin
				idx = g * dqe_pkg::TAP_GROUP + j;
				if (idx < CAPACITY) begin
					group_d[g] = group_d[g] | tap[idx];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUPS; g++) begin
			group_q[g] <= group_d[g];
		end
	end

	always_comb begin
		right_word = '0;
		for (int g = 0; g < GROUPS; g++) begin
			right_word = right_word | group_q[g];
		end
	end

endmodule

// File: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: decoder, cell chain, count and result register.
//
// Input channel (in_valid/in_ready) carries one operation: kind selects query,
// push right, push left, pop left or pop right, and value is the word to push.
// Output channel (out_valid/out_ready) returns one result per operation: the
// leftmost and rightmost words (0x7FFFFFFF when empty), the empty and full flags,
// the entry count and a flag for a push refused because the deque was full.
// Words live in a chain of CAPACITY cells packed from the left; a left push or
// pop shifts the whole chain by one place in the transfer cycle.
// The result register is loaded in the deliver state, which follows the gather state;
// the rightmost word passes through a registered OR tree over the cell taps, whose
// register stage lies ahead of the result register. A new operation is taken only
// in the idle state, after the previous one has passed the deliver state; it may be
// taken while the previous result is still waiting, and the next result then holds
// until the output register is free, with in_ready low meanwhile.
// Reset empties the deque and drops any pending result; the cell words need no
// clearing since only valid cells are ever reported.
module double_ended_queue #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] left_value,
	output logic signed [31:0] right_value,
	output logic        is_empty,
	output logic        is_full,
	output logic [6:0]  entry_count,
	output logic        dropped
);

	localparam int CW = $clog2(CAPACITY + 1);

	dqe_pkg::state_t           state_q;
	dqe_pkg::state_t           state_d;
	dqe_pkg::cell_ctrl_t       ctrl;
	logic                      accept;
	logic                      load_out;
	logic                      refuse;
	logic                      full;
	logic                      empty;
	logic [CW-1:0]             count_q;
	logic                      dropped_q;
	logic                      dropped_out_q;
	logic                      out_valid_q;
	logic [dqe_pkg::WORD_W-1:0] left_q;
	logic [dqe_pkg::WORD_W-1:0] right_q;
	logic                      empty_q;
	logic                      full_q;
	logic [dqe_pkg::COUNT_OUT_W-1:0] count_out_q;
	logic [dqe_pkg::WORD_W-1:0] right_word;

	logic [dqe_pkg::WORD_W-1:0] cell_word  [CAPACITY];
	logic                       cell_valid [CAPACITY];
	logic [dqe_pkg::WORD_W-1:0] cell_tap   [CAPACITY];

	assign accept = in_valid && in_ready;
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	// Operation decode; a push into a full deque or a pop from an empty one
	// leaves the cells alone.
	always_comb begin
		ctrl   = '0;
		refuse = 1'b0;
		if (accept) begin
			unique case (dqe_pkg::kind_t'(kind))
				dqe_pkg::KIND_PUSH_RIGHT: begin
					if (full) refuse = 1'b1;
					else ctrl.push_right = 1'b1;
				end
				dqe_pkg::KIND_PUSH_LEFT: begin
					if (full) refuse = 1'b1;
					else ctrl.push_left = 1'b1;
				end
				dqe_pkg::KIND_POP_LEFT: begin
					if (!empty) ctrl.pop_left = 1'b1;
				end
				dqe_pkg::KIND_POP_RIGHT: begin
					if (!empty) ctrl.pop_right = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push_left || ctrl.push_right) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.pop_left || ctrl.pop_right) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dropped_q <= refuse;
		end
	end

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [dqe_pkg::WORD_W-1:0] lw;
			logic                       lv;
			logic [dqe_pkg::WORD_W-1:0] rw;
			logic                       rv;

			if (i == 0) begin : g_first
				assign lw = value;
				assign lv = 1'b1;
			end else begin : g_inner_l
				assign lw = cell_word[i-1];
				assign lv = cell_valid[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign rw = cell_word[i];
				assign rv = 1'b0;
			end else begin : g_inner_r
				assign rw = cell_word[i+1];
				assign rv = cell_valid[i+1];
			end

			dqe_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.push_word   (value),
				.left_word   (lw),
				.left_valid  (lv),
				.right_word  (rw),
				.right_valid (rv),
				.word        (cell_word[i]),
				.valid       (cell_valid[i]),
				.tap         (cell_tap[i])
			);
		end
	endgenerate

	dqe_right_tap #(
		.CAPACITY (CAPACITY)
	) u_right_tap (
		.clk        (clk),
		.tap        (cell_tap),
		.right_word (right_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			dqe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = dqe_pkg::ST_GATHER;
			end
			dqe_pkg::ST_GATHER: begin
				state_d = dqe_pkg::ST_DELIVER;
			end
			dqe_pkg::ST_DELIVER: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = dqe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dqe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The refused flag is copied into the result register so that a following
	// transfer cannot disturb a result that is still waiting.
	always_ff @(posedge clk) begin
		if (load_out) begin
			left_q        <= empty ? dqe_pkg::EMPTY_WORD : cell_word[0];
			right_q       <= empty ? dqe_pkg::EMPTY_WORD : right_word;
			empty_q       <= empty;
			full_q        <= full;
			count_out_q   <= dqe_pkg::COUNT_OUT_W'(count_q);
			dropped_out_q <= dropped_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_value  = left_q;
	assign right_value = right_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign entry_count = count_out_q;
	assign dropped     = dropped_out_q;

endmodule
